// ===== hdl/rawd_pkg.sv =====
// rawd_pkg: shared constants, scan token, commit bundle and controller states
// for the room allocator; no dependencies
`default_nettype none

package rawd_pkg;

    localparam int MAX_ROOMS = 16;
    localparam int IDX_W     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CNT_W     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int IN_W      = 32;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int NR_W      = 5;
    localparam int ROOM_W    = 4;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [NR_W-1:0]    NUM_ROOMS_RESET = NR_W'(16);

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic               found;
        idx_t               free_idx;
        logic [COUNT_W-1:0] free_cnt;
        logic [TIME_W-1:0]  min_time;
        idx_t               min_idx;
        logic [COUNT_W-1:0] min_cnt;
        logic [COUNT_W-1:0] max_cnt;
        idx_t               max_idx;
    } token_t;

    typedef struct packed {
        logic              valid;
        logic              clear;
        idx_t              pick;
        logic [TIME_W-1:0] new_time;
    } commit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/rawd_cell.sv =====
// rawd_cell: one room's busy-until time and use count, plus one stage of the
// scan token chain; depends on rawd_pkg
`default_nettype none

module rawd_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             active,
    input  rawd_pkg::idx_t        cell_idx,
    input  wire logic [31:0]      start_time,
    input  rawd_pkg::token_t      tok_in,
    output rawd_pkg::token_t      tok_out,
    input  rawd_pkg::commit_t     commit
);
    import rawd_pkg::*;

    logic [TIME_W-1:0]  free_at_reg;
    logic [COUNT_W-1:0] use_count_reg;
    token_t             tok_reg;
    token_t             tok_next;

    always_comb begin
        tok_next = tok_in;
        if (active) begin
            if (!tok_in.found && free_at_reg <= {{(TIME_W-IN_W){1'b0}}, start_time}) begin
                tok_next.found    = 1'b1;
                tok_next.free_idx = cell_idx;
                tok_next.free_cnt = use_count_reg;
            end
            if (cell_idx == '0 || free_at_reg < tok_in.min_time) begin
                tok_next.min_time = free_at_reg;
                tok_next.min_idx  = cell_idx;
                tok_next.min_cnt  = use_count_reg;
            end
            if (use_count_reg > tok_in.max_cnt) begin
                tok_next.max_cnt = use_count_reg;
                tok_next.max_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_at_reg   <= '0;
            use_count_reg <= '0;
        end else if (commit.valid) begin
            if (commit.clear) begin
                free_at_reg   <= '0;
                use_count_reg <= '0;
            end else if (commit.pick == cell_idx) begin
                free_at_reg <= commit.new_time;
                if (use_count_reg != COUNT_MAX) begin
                    use_count_reg <= use_count_reg + 1'b1;
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== hdl/room_allocator_with_delay.sv =====
// room_allocator_with_delay: top level, request controller and the row of
// room cells; depends on rawd_pkg and rawd_cell
//
// usage:
//   s_* carries one request per transfer: s_tdata holds start and end time,
//   s_tlast marks the last request of a batch.
//   m_* returns one result per request: room, new busy-until and, on the
//   last request (m_tlast), the most used room; m_tuser is the delayed flag.
//   cfg_* writes the room count; it is always ready and is to be used while idle, which the block does not enforce.
// timing:
//   a request's scan token walks the room cells, one cell per cycle, then the
//   commit state picks the room, updates it and loads the output register.
//   a new request is taken only once the previous one has walked the cell
//   row and committed and the controller is back in idle.
// reset:
//   all rooms free with zero counts, room count 16, output empty.
// stall:
//   a held result stays in the output register; the next request is still
//   taken and scanned, and its commit waits until the output is free.
`default_nettype none

module room_allocator_with_delay (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // start_time[31:0], end_time[63:32]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // room[3:0], busy_until[51:4], most_booked[55:52]
    output logic             m_tuser,   // delayed
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import rawd_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IN_W-1:0]    start_reg;
    logic [IN_W-1:0]    dur_reg;
    logic               last_reg;
    logic [NR_W-1:0]    num_rooms_reg;

    logic               m_valid_reg, m_valid_next;
    logic [ROOM_W-1:0]  room_reg;
    logic               delayed_reg;
    logic [TIME_W-1:0]  busy_reg;
    logic [ROOM_W-1:0]  most_reg;
    logic               done_reg;

    token_t             init_tok;
    token_t             tok [MAX_ROOMS];
    logic [MAX_ROOMS-1:0] active;
    commit_t            commit;

    token_t             res_tok;
    idx_t               pick;
    logic [TIME_W-1:0]  base_time;
    logic [COUNT_W-1:0] pick_cnt;
    logic [COUNT_W-1:0] new_cnt;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  new_time;
    idx_t               top_idx;
    logic               in_xfer;
    logic               load_out;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        init_tok          = '0;
        init_tok.min_time = TIME_MAX;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_ROOMS; k++) begin : g_cell
            assign active[k] = (k == 0) || (32'(k) < 32'(num_rooms_reg));
            if (k == 0) begin : g_first
                rawd_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .active     (active[k]),
                    .cell_idx   (IDX_W'(k)),
                    .start_time (start_reg),
                    .tok_in     (init_tok),
                    .tok_out    (tok[k]),
                    .commit     (commit)
                );
            end else begin : g_rest
                rawd_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .active     (active[k]),
                    .cell_idx   (IDX_W'(k)),
                    .start_time (start_reg),
                    .tok_in     (tok[k-1]),
                    .tok_out    (tok[k]),
                    .commit     (commit)
                );
            end
        end
    endgenerate

    // room choice and new busy-until from the finished token
    always_comb begin
        res_tok = tok[MAX_ROOMS-1];
        if (res_tok.found) begin
            pick      = res_tok.free_idx;
            base_time = {{(TIME_W-IN_W){1'b0}}, start_reg};
            pick_cnt  = res_tok.free_cnt;
        end else begin
            pick      = res_tok.min_idx;
            base_time = res_tok.min_time;
            pick_cnt  = res_tok.min_cnt;
        end
        sum      = {1'b0, base_time} + {{(TIME_W+1-IN_W){1'b0}}, dur_reg};
        new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        new_cnt  = (pick_cnt == COUNT_MAX) ? pick_cnt : pick_cnt + 1'b1;
        if (new_cnt > res_tok.max_cnt ||
            (new_cnt == res_tok.max_cnt && pick < res_tok.max_idx)) begin
            top_idx = pick;
        end else begin
            top_idx = res_tok.max_idx;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        load_out        = 1'b0;
        m_valid_next    = m_valid_reg;
        commit.valid    = 1'b0;
        commit.clear    = last_reg;
        commit.pick     = pick;
        commit.new_time = new_time;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_xfer) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(MAX_ROOMS - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    commit.valid = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            num_rooms_reg <= NUM_ROOMS_RESET;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                num_rooms_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            start_reg <= s_tdata[31:0];
            dur_reg   <= (s_tdata[63:32] >= s_tdata[31:0]) ?
                         s_tdata[63:32] - s_tdata[31:0] : '0;
            last_reg  <= s_tlast;
        end
        if (load_out) begin
            room_reg    <= ROOM_W'(pick);
            delayed_reg <= !res_tok.found;
            busy_reg    <= new_time;
            most_reg    <= last_reg ? ROOM_W'(top_idx) : '0;
            done_reg    <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {most_reg, busy_reg, room_reg};
    assign m_tuser  = delayed_reg;
    assign m_tlast  = done_reg;

endmodule

`default_nettype wire

// ===== hdl/rawd_checker.sv =====
// rawd_checker: port-level assertions for room_allocator_with_delay, bound
// to the top level; no package dependency
`default_nettype none

module rawd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // output empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken during scan");

    // most used room only reported at batch end
    a_most_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[55:52] == 4'd0)
        else $error("most used room outside batch end");

endmodule

bind room_allocator_with_delay rawd_checker u_rawd_checker (.*);

`default_nettype wire
